// ----- hw/rtl/mpcl_pkg.sv -----
// Shared types, constants and saturating arithmetic for the min-plus lattice unit.
package mpcl_pkg;

  localparam int ENTRY_W     = 18;
  localparam int SUM_W       = 20;
  localparam int TOTAL_W     = 7;
  localparam int SYMBOL_W    = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int REG_INDEX_W = 1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 7'd64;
  localparam logic [SYMBOL_W-1:0] SYMBOL_RESET = 3'd4;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_TOTAL_COUNT  = 1'b0,
    REG_SYMBOL_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic step;
    logic copy;
  } fold_ctl_t;

  function automatic sum_t sat_add(sum_t a, entry_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W+1-ENTRY_W){b[ENTRY_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/mpcl_if.sv -----
// Request channel interfaces: input entries, results and configuration writes.
interface mpcl_in_if;
  import mpcl_pkg::*;
  logic   valid;
  logic   ready;
  entry_t entry_value;
  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

interface mpcl_out_if;
  import mpcl_pkg::*;
  logic valid;
  logic ready;
  sum_t min_entropy;
  modport source (output valid, output min_entropy, input ready);
  modport sink   (input valid, input min_entropy, output ready);
endinterface

interface mpcl_cfg_if;
  import mpcl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/mpcl_cell.sv -----
// One lattice cell: a row entry, a shifting minimum snapshot and a running minimum.
module mpcl_cell (
  input  logic                clk,
  input  logic                rst,
  input  mpcl_pkg::fold_ctl_t ctl,
  input  logic                row_wr,
  input  mpcl_pkg::entry_t    entry_value,
  input  mpcl_pkg::entry_t    row_in,
  input  mpcl_pkg::entry_t    row_head,
  input  mpcl_pkg::sum_t      snap_in,
  input  logic                snap_vld_in,
  input  logic                in_range,
  input  logic                is_last,
  output mpcl_pkg::entry_t    row_out,
  output mpcl_pkg::sum_t      snap_out,
  output logic                snap_vld_out,
  output mpcl_pkg::sum_t      acc_out
);
  import mpcl_pkg::*;

  entry_t row;
  sum_t   snap;
  logic   snap_vld;
  sum_t   acc;
  sum_t   cand;

  assign cand         = sat_add(snap, row_head);
  assign row_out      = row;
  assign snap_out     = snap;
  assign snap_vld_out = snap_vld;
  assign acc_out      = acc;

  always_ff @(posedge clk) begin
    if (row_wr) begin
      row <= entry_value;
    end else if (ctl.step) begin
      row <= row_in;
    end
    if (ctl.start) begin
      snap <= ctl.copy ? '0 : acc;
      if (ctl.copy) begin
        acc <= SUM_MAX;
      end
    end else if (ctl.step) begin
      snap <= snap_in;
      if (snap_vld && (cand < acc)) begin
        acc <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_vld <= 1'b0;
    end else if (ctl.start) begin
      snap_vld <= ctl.copy ? is_last : in_range;
    end else if (ctl.step) begin
      snap_vld <= snap_vld_in;
    end
  end

endmodule

// ----- hw/rtl/mpcl_ctrl.sv -----
// Sequencer: configuration registers, row and count tracking, fold steps and result register.
module mpcl_ctrl #(
  parameter int MAX_COUNT   = 64,
  parameter int MAX_SYMBOLS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [mpcl_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [mpcl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 cfg_ready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic                                 row_wr,
  output logic [$clog2(MAX_COUNT+1)-1:0]       pos,
  output logic [$clog2(MAX_COUNT+1)-1:0]       n_eff,
  output mpcl_pkg::fold_ctl_t                  fold,
  input  mpcl_pkg::sum_t                       acc_head,
  output logic                                 out_valid,
  output mpcl_pkg::sum_t                       out_value,
  input  logic                                 out_ready
);
  import mpcl_pkg::*;

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int RW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int KW = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [1:0] {IDLE, START, FOLD, EMIT} state_t;

  state_t                state;
  logic [TOTAL_W-1:0]    total_count;
  logic [SYMBOL_W-1:0]   symbol_count;
  logic [CW-1:0]         count_index;
  logic [RW-1:0]         row_index;
  logic [CW-1:0]         step_cnt;
  logic                  copy;
  logic                  last;
  logic [KW-1:0]         k_eff;
  logic                  accept;
  logic                  row_last;

  always_comb begin
    if (total_count == '0) begin
      n_eff = CW'(1);
    end else if (int'(total_count) > MAX_COUNT) begin
      n_eff = CW'(MAX_COUNT);
    end else begin
      n_eff = CW'(total_count);
    end
    if (symbol_count == '0) begin
      k_eff = KW'(1);
    end else if (int'(symbol_count) > MAX_SYMBOLS) begin
      k_eff = KW'(MAX_SYMBOLS);
    end else begin
      k_eff = KW'(symbol_count);
    end
  end

  assign pos        = (count_index > n_eff) ? n_eff : count_index;
  assign in_ready   = (state == IDLE);
  assign accept     = in_valid && in_ready;
  assign row_wr     = accept;
  assign row_last   = (int'(row_index) + 1) >= int'(k_eff);
  assign cfg_ready  = 1'b1;
  assign fold.start = (state == START);
  assign fold.step  = (state == FOLD);
  assign fold.copy  = copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      total_count  <= TOTAL_RESET;
      symbol_count <= SYMBOL_RESET;
      count_index  <= '0;
      row_index    <= '0;
      step_cnt     <= '0;
      copy         <= 1'b0;
      last         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOTAL_COUNT:  total_count  <= cfg_data[TOTAL_W-1:0];
          REG_SYMBOL_COUNT: symbol_count <= cfg_data[SYMBOL_W-1:0];
          default: ;
        endcase
      end
      if ((state == EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (count_index < n_eff) begin
              count_index <= count_index + 1'b1;
            end else begin
              count_index <= '0;
              copy        <= (row_index == '0);
              last        <= row_last;
              row_index   <= row_last ? '0 : RW'(row_index + 1'b1);
              state       <= START;
            end
          end
        end
        START: begin
          step_cnt <= '0;
          state    <= FOLD;
        end
        FOLD: begin
          if (step_cnt == n_eff) begin
            state <= last ? EMIT : IDLE;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        EMIT: begin
          if (!out_valid || out_ready) begin
            out_value <= acc_head;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/min_plus_convolution_lattice_unit.sv -----
// Top level of the min-plus convolution lattice unit.
//
// Channels: in_ch carries one signed 18-bit table entry per request, row by
// row (one row per symbol), each row running from count 0 to count N.
// cfg_ch writes total_count (index 0) and symbol_count (index 1); it is
// always ready and should only be used while the unit is idle.
// out_ch carries the signed 20-bit minimum total at count N, one request per
// full set of rows.
// Throughput: an entry that does not end a row is taken while the unit is
// idle, and the unit stays ready for the next one. An entry that ends a row
// holds off input while the row is folded across a chain of MAX_COUNT+1
// cells: a set-up state, then N+1 steps, each cell doing one saturating add
// and compare per step. After the last row, input stays held off until the
// result enters the output register.
// After the last entry of the last row is accepted, the result passes the
// START and FOLD states and is registered from the EMIT state.
// Reset: counters return to row 0, count 0; total_count returns to 64 and
// symbol_count to 4. Cell entries, snapshots and minima are not cleared.
// Back-pressure: the result sits in an output register; a new fold may run
// while it waits, and the next result is held until that register is free.
module min_plus_convolution_lattice_unit #(
  parameter int MAX_COUNT   = 64,
  parameter int MAX_SYMBOLS = 4
) (
  input  logic       clk,
  input  logic       rst,
  mpcl_in_if.sink    in_ch,
  mpcl_out_if.source out_ch,
  mpcl_cfg_if.sink   cfg_ch
);
  import mpcl_pkg::*;

  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int CELLS = MAX_COUNT + 1;

  fold_ctl_t     fold;
  logic          row_wr;
  logic [CW-1:0] pos;
  logic [CW-1:0] n_eff;
  sum_t          acc_head;

  entry_t row_w      [0:CELLS];
  sum_t   snap_w     [0:CELLS];
  logic   snap_vld_w [0:CELLS];

  assign row_w[CELLS]      = '0;
  assign snap_w[CELLS]     = '0;
  assign snap_vld_w[CELLS] = 1'b0;

  mpcl_ctrl #(
    .MAX_COUNT   (MAX_COUNT),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg_ready (cfg_ch.ready),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .row_wr    (row_wr),
    .pos       (pos),
    .n_eff     (n_eff),
    .fold      (fold),
    .acc_head  (acc_head),
    .out_valid (out_ch.valid),
    .out_value (out_ch.min_entropy),
    .out_ready (out_ch.ready)
  );

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(c);
    sum_t acc;

    mpcl_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (fold),
      .row_wr       (row_wr && (pos == IDX)),
      .entry_value  (in_ch.entry_value),
      .row_in       (row_w[c+1]),
      .row_head     (row_w[0]),
      .snap_in      (snap_w[c+1]),
      .snap_vld_in  (snap_vld_w[c+1]),
      .in_range     (IDX <= n_eff),
      .is_last      (IDX == n_eff),
      .row_out      (row_w[c]),
      .snap_out     (snap_w[c]),
      .snap_vld_out (snap_vld_w[c]),
      .acc_out      (acc)
    );

    if (c == 0) begin : g_head
      assign acc_head = acc;
    end
  end

endmodule

// ----- hw/rtl/mpcl_checker.sv -----
// Port-level checks for the min-plus lattice unit, bound to its top level.
module mpcl_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mpcl_pkg::sum_t min_entropy
);
  import mpcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_entropy))
    else $error("result dropped or changed while stalled");

  a_result_after_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a preceding fold");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input stalled without an accepted request");

endmodule

bind min_plus_convolution_lattice_unit mpcl_checker u_mpcl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .min_entropy (out_ch.min_entropy)
);

// ----- tb/tb_min_plus_convolution_lattice_unit.sv -----
// Self-checking testbench for the min-plus convolution lattice unit.
`timescale 1ns / 1ps

module tb_min_plus_convolution_lattice_unit;
  import mpcl_pkg::*;

  localparam int MAX_COUNT   = 64;
  localparam int MAX_SYMBOLS = 4;
  localparam int SETTLE      = 80;
  localparam int ITEMS       = 1700;
  localparam int FIXED_ITEMS = 400;

  logic clk;
  logic rst;

  mpcl_in_if  in_ch ();
  mpcl_out_if out_ch ();
  mpcl_cfg_if cfg_ch ();

  min_plus_convolution_lattice_unit #(
    .MAX_COUNT  (MAX_COUNT),
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // lattice shadow state
  sum_t                minima [0:MAX_COUNT];
  entry_t              row_buf[0:MAX_COUNT];
  int unsigned         row_idx;
  int unsigned         count_idx;
  logic [TOTAL_W-1:0]  total_reg;
  logic [SYMBOL_W-1:0] symbol_reg;

  sum_t pending_minima[$];

  int send_idle_pct;
  int recv_idle_pct;
  int entries_sent;
  int totals_checked;
  int cfg_writes;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $error("timeout with %0d minimum totals outstanding", pending_minima.size());
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned eff_total();
    if (total_reg < 1) return 1;
    if (total_reg > MAX_COUNT) return MAX_COUNT;
    return total_reg;
  endfunction

  function automatic int unsigned eff_symbols();
    if (symbol_reg < 1) return 1;
    if (symbol_reg > MAX_SYMBOLS) return MAX_SYMBOLS;
    return symbol_reg;
  endfunction

  function automatic sum_t clamp_sum(int s);
    if (s > int'(SUM_MAX)) return SUM_MAX;
    if (s < int'(SUM_MIN)) return SUM_MIN;
    return sum_t'(s);
  endfunction

  task automatic absorb_entry(entry_t v);
    int unsigned n_max;
    int unsigned pos;
    int          n;
    int          j;
    sum_t        cand;
    n_max = eff_total();
    pos   = (count_idx > n_max) ? n_max : count_idx;
    row_buf[pos] = v;
    if (count_idx < n_max) begin
      count_idx++;
      return;
    end
    count_idx = 0;
    if (row_idx == 0) begin
      for (n = 0; n <= n_max; n++) minima[n] = sum_t'(row_buf[n]);
    end else begin
      for (n = n_max; n >= 0; n--) begin
        for (j = n; j >= 0; j--) begin
          cand = clamp_sum(int'(minima[j]) + int'(row_buf[n-j]));
          if (cand < minima[n]) minima[n] = cand;
        end
      end
    end
    if (row_idx + 1 >= eff_symbols()) begin
      row_idx = 0;
      pending_minima.push_back(minima[n_max]);
    end else begin
      row_idx++;
    end
  endtask

  task automatic send_entry(entry_t v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.entry_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_entry(v);
    entries_sent++;
  endtask

  // drop the request line and wait out every outstanding total
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_minima.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_TOTAL_COUNT:  total_reg  = data[TOTAL_W-1:0];
      REG_SYMBOL_COUNT: symbol_reg = data[SYMBOL_W-1:0];
      default:          ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] total, logic [CFG_DATA_W-1:0] symbols);
    drain();
    write_reg(REG_TOTAL_COUNT, total);
    write_reg(REG_SYMBOL_COUNT, symbols);
  endtask

  function automatic entry_t random_entry();
    int pick;
    int s;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? entry_t'(18'sh1FFFF) : entry_t'(18'sh20000);
    if (pick < 55) return entry_t'($urandom);
    s = $urandom_range(400);
    return entry_t'(s - 200);
  endfunction

  task automatic send_sets(int sets);
    int s;
    int i;
    for (s = 0; s < sets; s++) begin
      for (i = 0; i < eff_symbols() * (eff_total() + 1); i++) send_entry(random_entry());
    end
  endtask

  task automatic test_single_row_extremes();
    configure(7'd1, 7'd1);
    send_entry(18'sh1FFFF);
    send_entry(18'sh1FFFF);
    send_entry(18'sh20000);
    send_entry(18'sh20000);
    send_entry(18'sh00000);
    send_entry(-18'sd1);
  endtask

  task automatic test_zero_counts_clamped();
    configure(7'd0, 7'd0);
    send_entry(18'sh15555);
    send_entry(18'sh2AAAA);
  endtask

  task automatic test_multi_row_fold();
    entry_t vals[12] = '{18'sh1FFFF, 18'sh20000, 18'sh00000,
                         18'sh20000, 18'sh1FFFF, -18'sd1,
                         18'sh20000, 18'sh20000, 18'sh20000,
                         18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF};
    int i;
    configure(7'd2, 7'd4);
    for (i = 0; i < 12; i++) send_entry(vals[i]);
  endtask

  task automatic test_full_lattice_clamped();
    configure(7'd127, 7'd7);
    send_sets(1);
  endtask

  task automatic test_random_lattices(int budget);
    int                      stop_at;
    int                      pick;
    logic [CFG_DATA_W-1:0]   total;
    logic [CFG_DATA_W-1:0]   symbols;
    stop_at = entries_sent + budget;
    while (entries_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5)       total = 7'd127;
      else if (pick < 9)  total = 7'd64;
      else if (pick < 15) total = 7'd0;
      else if (pick < 22) total = 7'(96 + $urandom_range(31));
      else                total = 7'($urandom_range(1, 10));
      symbols = 7'($urandom);
      if ($urandom_range(3) != 0) symbols[SYMBOL_W-1:0] = 3'($urandom_range(1, 4));
      configure(total, symbols);
      if (eff_total() * eff_symbols() > 64) send_sets(1);
      else send_sets($urandom_range(2, 5));
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_minima.size() == 0) begin
        $error("min_entropy: no total expected, got %0d", out_ch.min_entropy);
        mismatches++;
      end else begin
        if (out_ch.min_entropy !== pending_minima[0]) begin
          $error("min_entropy: expected %0d, got %0d", pending_minima[0], out_ch.min_entropy);
          mismatches++;
        end
        void'(pending_minima.pop_front());
        totals_checked++;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.entry_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TOTAL_COUNT;
    cfg_ch.data       = '0;
    total_reg         = TOTAL_RESET;
    symbol_reg        = SYMBOL_RESET;
    row_idx           = 0;
    count_idx         = 0;
    for (int i = 0; i <= MAX_COUNT; i++) begin
      minima[i]  = '0;
      row_buf[i] = '0;
    end
    send_idle_pct  = 35;
    recv_idle_pct  = 72;
    entries_sent   = 0;
    totals_checked = 0;
    cfg_writes     = 0;
    mismatches     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_row_extremes();
    test_zero_counts_clamped();
    test_multi_row_fold();
    test_full_lattice_clamped();
    test_random_lattices((ITEMS - FIXED_ITEMS) / 3);
    send_idle_pct = 72;
    recv_idle_pct = 35;
    test_random_lattices((ITEMS - FIXED_ITEMS) / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lattices((ITEMS - FIXED_ITEMS) / 3);
    drain();

    $display("%0d table entries sent over %0d register writes, %0d minimum totals checked",
             entries_sent, cfg_writes, totals_checked);
    $display("counts and symbol numbers swept through clamped extremes under three stall mixes");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
